### hdl/sdss_pkg.sv
package sdss_pkg;

  // Sizes of the stored batch and of the fields
  localparam int unsigned MaxReq  = 16;
  localparam int unsigned TrackW  = 16;
  localparam int unsigned CntW    = $clog2(MaxReq + 1);
  localparam int unsigned IdxW    = $clog2(MaxReq);
  localparam int unsigned DiskW   = 17;
  localparam int unsigned TotalW  = 21;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OutDataW = 72;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDiskSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeadStart = 1'b1;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              ins;  // insert key into the sorted row
    logic              clr;  // empty the row
    logic [TrackW-1:0] key;  // insertion value, or head start when counting
  } chain_ctrl_t;

endpackage

### hdl/sdss_cell.sv
module sdss_cell
  import sdss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chain_ctrl_t       ctrl_i,
  input  logic              left_gt_i,
  input  logic              left_valid_i,
  input  logic [TrackW-1:0] left_val_i,
  output logic              gt_o,
  output logic              lt_o,
  output logic              valid_o,
  output logic [TrackW-1:0] val_o
);

  logic              valid_q, valid_d;
  logic [TrackW-1:0] val_q, val_d;

  // An empty cell counts as larger than any key
  assign gt_o    = !valid_q || (val_q > ctrl_i.key);
  assign lt_o    = valid_q && (val_q < ctrl_i.key);
  assign valid_o = valid_q;
  assign val_o   = val_q;

  // Shift right from the left neighbour, or take the key at the gap
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        valid_d = left_valid_i;
        val_d   = left_val_i;
      end else begin
        valid_d = 1'b1;
        val_d   = ctrl_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### hdl/sdss_chain.sv
module sdss_chain
  import sdss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chain_ctrl_t       ctrl_i,
  input  logic [IdxW-1:0]   rd_idx_i,
  output logic [TrackW-1:0] rd_val_o,
  output logic [CntW-1:0]   below_cnt_o
);

  logic [MaxReq-1:0]              gt;
  logic [MaxReq-1:0]              lt;
  logic [MaxReq-1:0]              valid;
  logic [MaxReq-1:0][TrackW-1:0]  val;

  // Row of sorted cells, smallest at cell 0
  for (genvar i = 0; i < MaxReq; i++) begin : g_cell
    if (i == 0) begin : g_first
      sdss_cell u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i,
        .left_gt_i    (1'b0),
        .left_valid_i (1'b0),
        .left_val_i   ('0),
        .gt_o         (gt[i]),
        .lt_o         (lt[i]),
        .valid_o      (valid[i]),
        .val_o        (val[i])
      );
    end else begin : g_next
      sdss_cell u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i,
        .left_gt_i    (gt[i-1]),
        .left_valid_i (valid[i-1]),
        .left_val_i   (val[i-1]),
        .gt_o         (gt[i]),
        .lt_o         (lt[i]),
        .valid_o      (valid[i]),
        .val_o        (val[i])
      );
    end
  end

  // Single read port for the schedule walk
  assign rd_val_o    = val[rd_idx_i];
  // Stored requests below the key
  assign below_cnt_o = CntW'($countones(lt));

endmodule

### hdl/scan_disk_seek_scheduler.sv
// Loading: a request item is taken by insertion into the sorted cell row.
// After the item marked tlast, the StPrep state counts the requests below the head start;
// then one move leaves per cycle while the result side is ready: up to 17 moves.
// Throughput: one request per cycle while loading; no request is taken during the walk.
// Reset (rst_ni low, asynchronous): row empty, disk_size 200, head_start 0, idle.
module scan_disk_seek_scheduler
  import sdss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] request_track
  input  logic                s_axis_tlast,   // last_request
  // Move stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [15:0] from_track, [31:16] to_track,
                                              // [47:32] move_distance,
                                              // [68:48] total_distance, rest zero
  output logic                m_axis_tlast,   // last_move
  output logic                m_axis_tuser,   // [0] requests_dropped
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DiskW-1:0]    cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StUp   = 2'd2;
  localparam logic [1:0] StDown = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [DiskW-1:0]  disk_q;
  logic [TrackW-1:0] head_q;
  logic [CntW-1:0]   cnt_q;
  logic              ovf_q;
  logic [CntW-1:0]   p_q;
  logic [CntW-1:0]   idx_q;
  logic [TrackW-1:0] end_q;
  logic [TrackW-1:0] cur_q;
  logic [TotalW-1:0] total_q;

  logic              out_valid_q;
  logic [TrackW-1:0] out_from_q, out_to_q, out_dist_q;
  logic [TotalW-1:0] out_total_q;
  logic              out_last_q, out_drop_q;

  logic [TrackW-1:0] end_w, h_w, t_sat, rd_val, to_w, dist_w;
  logic [CntW-1:0]   below_cnt;
  logic [TotalW-1:0] total_w;
  logic              accept_in, full, step, at_end, mv_last;
  chain_ctrl_t       ctrl;

  // Last track of the disk, saturated to the track range
  always_comb begin
    if (disk_q == '0) begin
      end_w = '0;
    end else if (disk_q > DiskW'({TrackW{1'b1}}) + DiskW'(1)) begin
      end_w = '1;
    end else begin
      end_w = TrackW'(disk_q - DiskW'(1));
    end
  end

  assign h_w   = (head_q > end_w) ? end_w : head_q;
  assign t_sat = (s_axis_tdata > end_w) ? end_w : s_axis_tdata;

  assign s_axis_tready = (state_q == StIdle);
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CntW'(MaxReq));
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q <= DiskW'(200);
      head_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDiskSize:  disk_q <= cfg_data_i;
        RegHeadStart: head_q <= cfg_data_i[TrackW-1:0];
        default: ;
      endcase
    end
  end

  // Move generation
  assign step    = ((state_q == StUp) || (state_q == StDown)) &&
                   (!out_valid_q || m_axis_tready);
  assign at_end  = (state_q == StUp) && (idx_q == cnt_q);
  assign to_w    = at_end ? end_q : rd_val;
  assign dist_w  = (to_w >= cur_q) ? (to_w - cur_q) : (cur_q - to_w);
  assign total_w = total_q + TotalW'(dist_w);
  assign mv_last = (state_q == StUp) ? (at_end && (p_q == '0)) : (idx_q == '0);

  assign ctrl.key = (state_q == StIdle) ? t_sat : h_w;
  assign ctrl.ins = accept_in && !full;
  assign ctrl.clr = step && mv_last;

  sdss_chain u_chain (
    .clk_i,
    .rst_ni,
    .ctrl_i      (ctrl),
    .rd_idx_i    (idx_q[IdxW-1:0]),
    .rd_val_o    (rd_val),
    .below_cnt_o (below_cnt)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept_in && s_axis_tlast) state_d = StPrep;
      StPrep: state_d = StUp;
      StUp: begin
        if (step && at_end) state_d = (p_q == '0) ? StIdle : StDown;
      end
      StDown: if (step && mv_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      p_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.ins) cnt_q <= cnt_q + CntW'(1);
      if (accept_in && full) ovf_q <= 1'b1;
      if (state_q == StPrep) begin
        p_q   <= below_cnt;
        idx_q <= below_cnt;
      end else if (step) begin
        if (state_q == StUp) begin
          idx_q <= at_end ? (p_q - CntW'(1)) : (idx_q + CntW'(1));
        end else if (!mv_last) begin
          idx_q <= idx_q - CntW'(1);
        end
      end
      if (ctrl.clr) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  // Walk position and running total
  always_ff @(posedge clk_i) begin
    if (state_q == StPrep) begin
      end_q   <= end_w;
      cur_q   <= h_w;
      total_q <= '0;
    end else if (step) begin
      cur_q   <= to_w;
      total_q <= total_w;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_from_q  <= cur_q;
      out_to_q    <= to_w;
      out_dist_q  <= dist_w;
      out_total_q <= total_w;
      out_last_q  <= mv_last;
      out_drop_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_total_q, out_dist_q, out_to_q, out_from_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxReq))
    else $error("entry count beyond capacity");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && mv_last |=> (state_q == StIdle) && (cnt_q == '0) && !ovf_q)
    else $error("batch not cleared after final move");

  a_down_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDown) |-> (p_q != '0) && (idx_q < p_q))
    else $error("downward walk index out of range");

  a_up_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUp) |-> (idx_q <= cnt_q) && (idx_q >= p_q))
    else $error("upward walk index out of range");

endmodule
